@@ hw/rtl/yee_pkg.sv @@
// Package: widths, codes and decode helpers for the Yee curl update block.
`timescale 1ns / 1ps

package yee_pkg;

    localparam int FIELD_BITS = 32;
    localparam int FRAC_BITS  = 16;
    localparam int COEF_BITS  = 31;
    localparam int WALL_BITS  = 32;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;

    localparam int DIFF_BITS = FIELD_BITS + 1;
    localparam int PROD_BITS = DIFF_BITS + COEF_BITS + 1;
    localparam int ACC_BITS  = PROD_BITS + 2;
    localparam int SHR_BITS  = ACC_BITS - FRAC_BITS;
    localparam int SUM_BITS  = SHR_BITS + 1;

    localparam int IN_USER_BITS  = 6;
    localparam int IN_DATA_BITS  = 6 * FIELD_BITS;
    localparam int OUT_USER_BITS = 1;
    localparam int OUT_DATA_BITS = ((FIELD_BITS + 7) / 8) * 8;

    localparam logic signed [FIELD_BITS-1:0] FIELD_MAX = {1'b0, {(FIELD_BITS-1){1'b1}}};
    localparam logic signed [FIELD_BITS-1:0] FIELD_MIN = {1'b1, {(FIELD_BITS-1){1'b0}}};

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_CDT_DX     = 3'd0,
        REG_CDT_DY     = 3'd1,
        REG_CDT_DZ     = 3'd2,
        REG_FLUX_GAIN  = 3'd3,
        REG_BOUND_MODE = 3'd4,
        REG_WALL_Y     = 3'd5,
        REG_WALL_Z     = 3'd6
    } cfg_reg_t;

    typedef enum logic [2:0] {
        COMP_EX = 3'd0,
        COMP_EY = 3'd1,
        COMP_EZ = 3'd2,
        COMP_BX = 3'd3,
        COMP_BY = 3'd4,
        COMP_BZ = 3'd5
    } comp_t;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    localparam logic [1:0] FACE_LOW  = 2'd1;
    localparam logic [1:0] FACE_HIGH = 2'd2;

    typedef struct packed {
        logic  known;
        logic  is_e;
        logic  neg_first;
        axis_t first_axis;
        axis_t second_axis;
    } comp_sel_t;

    function automatic comp_sel_t comp_decode(input logic [2:0] rt);
        comp_sel_t s;
        s = '{known: 1'b1, is_e: 1'b0, neg_first: 1'b0,
              first_axis: AXIS_X, second_axis: AXIS_X};
        case (rt)
            COMP_EX:
            begin
                s.is_e = 1'b1; s.first_axis = AXIS_Y; s.second_axis = AXIS_Z;
            end
            COMP_EY:
            begin
                s.is_e = 1'b1; s.neg_first = 1'b1;
                s.first_axis = AXIS_X; s.second_axis = AXIS_Z;
            end
            COMP_EZ:
            begin
                s.is_e = 1'b1; s.first_axis = AXIS_X; s.second_axis = AXIS_Y;
            end
            COMP_BX:
            begin
                s.neg_first = 1'b1; s.first_axis = AXIS_Y; s.second_axis = AXIS_Z;
            end
            COMP_BY:
            begin
                s.first_axis = AXIS_X; s.second_axis = AXIS_Z;
            end
            COMP_BZ:
            begin
                s.first_axis = AXIS_Y; s.second_axis = AXIS_X;
            end
            default:
            begin
                s.known = 1'b0;
            end
        endcase
        return s;
    endfunction

endpackage

@@ hw/rtl/yee_curl_field_update.sv @@
// Top level: pipelined Yee-grid curl update for one field component per transfer.
// Pipeline registers: input, product and result, in that order, between an input transfer and
// its result transfer. Throughput: one transfer per cycle unless m_tready stalls the output.
// Three 33x32 multipliers set the product stage.
// A stalled result holds in the result register while earlier stages keep filling.
// Reset (rst_n low, asynchronous): pipeline empties and all configuration registers clear to 0.
`timescale 1ns / 1ps

module yee_curl_field_update
    import yee_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // old_value, first_right, first_left, second_right, second_left, flux_density
    input  logic [IN_DATA_BITS-1:0]   s_tdata,
    // req_type, half_step, x_face
    input  logic [IN_USER_BITS-1:0]   s_tuser,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // new_value
    output logic [OUT_DATA_BITS-1:0]  m_tdata,
    // saturated
    output logic [OUT_USER_BITS-1:0]  m_tuser,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    logic [COEF_BITS-1:0]        cdx_reg, cdy_reg, cdz_reg, gain_reg;
    logic                        mode_reg;
    logic signed [WALL_BITS-1:0] wall_y_reg, wall_z_reg;

    logic a_v_reg, b_v_reg, c_v_reg;
    logic a_adv, b_adv, c_adv;

    logic [2:0]                   a_type_reg;
    logic                         a_half_reg;
    logic [1:0]                   a_face_reg;
    logic signed [FIELD_BITS-1:0] a_old_reg, a_fr_reg, a_fl_reg, a_sr_reg, a_sl_reg, a_j_reg;

    logic signed [PROD_BITS-1:0]  b_p1_reg, b_p2_reg, b_p3_reg;
    logic signed [PROD_BITS-1:0]  b_p1_next, b_p2_next, b_p3_next;
    logic                         b_half_reg;
    logic                         b_curl_reg, b_curl_next;
    logic signed [FIELD_BITS-1:0] b_old_reg;
    logic signed [SUM_BITS-1:0]   b_byp_reg, b_byp_next;

    logic signed [FIELD_BITS-1:0] c_val_reg, c_val_next;
    logic                         c_sat_reg, c_sat_next;

    comp_sel_t                    sel;
    logic [COEF_BITS-1:0]         ca, cb;
    logic signed [DIFF_BITS-1:0]  d1, d2, t1, t2, nj;
    logic signed [ACC_BITS-1:0]   acc, acc_sh;
    logic signed [SUM_BITS-1:0]   sum, cand;
    logic                         wall_hit;

    function automatic logic [COEF_BITS-1:0] pick_coef(
        input axis_t                ax,
        input logic [COEF_BITS-1:0] cx,
        input logic [COEF_BITS-1:0] cy,
        input logic [COEF_BITS-1:0] cz
    );
        logic [COEF_BITS-1:0] r;
        case (ax)
            AXIS_X:  r = cx;
            AXIS_Y:  r = cy;
            AXIS_Z:  r = cz;
            default: r = '0;
        endcase
        return r;
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cdx_reg    <= '0;
            cdy_reg    <= '0;
            cdz_reg    <= '0;
            gain_reg   <= '0;
            mode_reg   <= 1'b0;
            wall_y_reg <= '0;
            wall_z_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_CDT_DX:     cdx_reg    <= cfg_data[COEF_BITS-1:0];
                REG_CDT_DY:     cdy_reg    <= cfg_data[COEF_BITS-1:0];
                REG_CDT_DZ:     cdz_reg    <= cfg_data[COEF_BITS-1:0];
                REG_FLUX_GAIN:  gain_reg   <= cfg_data[COEF_BITS-1:0];
                REG_BOUND_MODE: mode_reg   <= cfg_data[0];
                REG_WALL_Y:     wall_y_reg <= cfg_data[WALL_BITS-1:0];
                REG_WALL_Z:     wall_z_reg <= cfg_data[WALL_BITS-1:0];
                default:        ;
            endcase
        end
    end

    // stage flow control
    assign c_adv    = !c_v_reg || m_tready;
    assign b_adv    = !b_v_reg || c_adv;
    assign a_adv    = !a_v_reg || b_adv;
    assign s_tready = a_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
        end
        else
        begin
            if (a_adv)
            begin
                a_v_reg <= s_tvalid;
            end
            if (b_adv)
            begin
                b_v_reg <= a_v_reg;
            end
            if (c_adv)
            begin
                c_v_reg <= b_v_reg;
            end
        end
    end

    // product stage
    always_comb
    begin
        sel = comp_decode(a_type_reg);
        ca  = pick_coef(sel.first_axis, cdx_reg, cdy_reg, cdz_reg);
        cb  = pick_coef(sel.second_axis, cdx_reg, cdy_reg, cdz_reg);
        d1  = DIFF_BITS'(a_fr_reg) - DIFF_BITS'(a_fl_reg);
        d2  = DIFF_BITS'(a_sr_reg) - DIFF_BITS'(a_sl_reg);
        t1  = sel.neg_first ? -d1 : d1;
        t2  = sel.neg_first ? d2 : -d2;
        nj  = -DIFF_BITS'(a_j_reg);

        b_p1_next = PROD_BITS'(t1) * PROD_BITS'($signed({1'b0, ca}));
        b_p2_next = PROD_BITS'(t2) * PROD_BITS'($signed({1'b0, cb}));
        b_p3_next = sel.is_e ? PROD_BITS'(nj) * PROD_BITS'($signed({1'b0, gain_reg})) : '0;

        wall_hit = mode_reg && sel.known && (a_type_reg == COMP_EY || a_type_reg == COMP_EZ)
                   && (a_face_reg == FACE_LOW || a_face_reg == FACE_HIGH);

        b_curl_next = sel.known && !wall_hit;
        if (!sel.known)
        begin
            b_byp_next = SUM_BITS'(a_old_reg);
        end
        else if (wall_hit && a_face_reg == FACE_HIGH)
        begin
            b_byp_next = (a_type_reg == COMP_EY) ? SUM_BITS'(wall_y_reg)
                                                 : SUM_BITS'(wall_z_reg);
        end
        else
        begin
            b_byp_next = '0;
        end
    end

    // result stage
    always_comb
    begin
        acc    = ACC_BITS'(b_p1_reg) + ACC_BITS'(b_p2_reg) + ACC_BITS'(b_p3_reg);
        acc_sh = b_half_reg ? (acc >>> (FRAC_BITS + 1)) : (acc >>> FRAC_BITS);
        sum    = SUM_BITS'($signed(acc_sh[SHR_BITS-1:0])) + SUM_BITS'(b_old_reg);
        cand   = b_curl_reg ? sum : b_byp_reg;
        if (cand > SUM_BITS'(FIELD_MAX))
        begin
            c_val_next = FIELD_MAX;
            c_sat_next = 1'b1;
        end
        else if (cand < SUM_BITS'(FIELD_MIN))
        begin
            c_val_next = FIELD_MIN;
            c_sat_next = 1'b1;
        end
        else
        begin
            c_val_next = cand[FIELD_BITS-1:0];
            c_sat_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_adv && s_tvalid)
        begin
            a_type_reg <= s_tuser[2:0];
            a_half_reg <= s_tuser[3];
            a_face_reg <= s_tuser[5:4];
            a_old_reg  <= s_tdata[0*FIELD_BITS +: FIELD_BITS];
            a_fr_reg   <= s_tdata[1*FIELD_BITS +: FIELD_BITS];
            a_fl_reg   <= s_tdata[2*FIELD_BITS +: FIELD_BITS];
            a_sr_reg   <= s_tdata[3*FIELD_BITS +: FIELD_BITS];
            a_sl_reg   <= s_tdata[4*FIELD_BITS +: FIELD_BITS];
            a_j_reg    <= s_tdata[5*FIELD_BITS +: FIELD_BITS];
        end
        if (b_adv && a_v_reg)
        begin
            b_p1_reg   <= b_p1_next;
            b_p2_reg   <= b_p2_next;
            b_p3_reg   <= b_p3_next;
            b_half_reg <= a_half_reg;
            b_curl_reg <= b_curl_next;
            b_old_reg  <= a_old_reg;
            b_byp_reg  <= b_byp_next;
        end
        if (c_adv && b_v_reg)
        begin
            c_val_reg <= c_val_next;
            c_sat_reg <= c_sat_next;
        end
    end

    assign m_tvalid = c_v_reg;
    assign m_tdata  = OUT_DATA_BITS'(c_val_reg);
    assign m_tuser  = OUT_USER_BITS'(c_sat_reg);

`ifndef SYNTHESIS
    a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (c_v_reg && c_sat_reg) |-> (c_val_reg == FIELD_MAX || c_val_reg == FIELD_MIN))
        else $error("saturation flag set on an unclipped value");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (a_v_reg && b_v_reg && c_v_reg && !m_tready) |-> !s_tready)
        else $error("input taken while pipeline is full and stalled");

    a_fill_count: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !(m_tvalid && m_tready)) |=>
        ($countones({a_v_reg, b_v_reg, c_v_reg}) ==
         $past($countones({a_v_reg, b_v_reg, c_v_reg})) + 1))
        else $error("pipeline occupancy lost or duplicated a transfer");

    a_bypass_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (b_v_reg && c_adv && !b_curl_reg && b_byp_reg == '0) |=> (!c_sat_reg && c_val_reg == '0))
        else $error("forced-zero result corrupted");
`endif

endmodule
